// File: design/pfi_pkg.sv
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared constants and types for the palette find-or-insert block.
// ----------------------------------------------------------------------------
package pfi_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int COLOR_W       = 24;
  localparam int IDX_W         = 8;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

endpackage

// File: design/pfi_in_if.sv
// ----------------------------------------------------------------------------
// pfi_in_if
// Request channel: one RGB color per request.
// ----------------------------------------------------------------------------
interface pfi_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// File: design/pfi_out_if.sv
// ----------------------------------------------------------------------------
// pfi_out_if
// Result channel: palette index and status.
// ----------------------------------------------------------------------------
interface pfi_out_if import pfi_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] palette_index;
  status_t          status;

  modport source (output valid, output palette_index, output status, input ready);
  modport sink   (input valid, input palette_index, input status, output ready);

endinterface

// File: design/palette_find_or_insert.sv
// ----------------------------------------------------------------------------
// palette_find_or_insert
// Search: one palette RAM read per cycle, each entry compared the cycle after
//   its read; stops at a match or the last entry, skipped on an empty palette.
// Requests: one at a time; next request taken once the result is
//   in the output register.
// Reset: synchronous; clears the entry count and control state. Palette RAM
//   is not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module palette_find_or_insert import pfi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pfi_in_if.sink    in_ch,
  pfi_out_if.source out_ch
);

  logic [COLOR_W-1:0] store [PALETTE_DEPTH];

  state_t             state;
  state_t             state_next;
  logic [COLOR_W-1:0] color;
  logic [CNT_W-1:0]   scan;
  logic [CNT_W-1:0]   count;
  logic               rd_vld;
  logic [ADDR_W-1:0]  rd_idx;
  logic [COLOR_W-1:0] rdata;
  logic [IDX_W-1:0]   res_index;
  status_t            res_status;
  logic               out_vld;
  logic [IDX_W-1:0]   out_index;
  status_t            out_status;

  logic                   rd_en;
  logic                   match;
  logic                   last;
  logic                   full;
  logic                   done;
  logic                   wr_en;
  logic                   out_load;
  logic [IDX_W-1:0]       idx_val;
  status_t                st_val;
  logic [CNT_W+IDX_W-1:0] ext_rd;
  logic [CNT_W+IDX_W-1:0] ext_cnt;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_ch.valid) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_vld || out_ch.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ext_rd   = {{IDX_W{1'b0}}, CNT_W'(rd_idx)};
    ext_cnt  = {{IDX_W{1'b0}}, count};
    match    = rd_vld && (rdata == color);
    last     = rd_vld && ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
    full     = (count == CNT_W'(PALETTE_DEPTH));
    rd_en    = (state == S_SEARCH) && (scan < count);
    done     = (state == S_SEARCH) && ((count == '0) || match || last);
    wr_en    = 1'b0;
    out_load = (state == S_DONE) && (!out_vld || out_ch.ready);
    idx_val  = '0;
    st_val   = ST_FULL;
    if (match) begin
      idx_val = ext_rd[IDX_W-1:0];
      st_val  = ST_FOUND;
    end else if (!full) begin
      idx_val = ext_cnt[IDX_W-1:0];
      st_val  = ST_ADDED;
      wr_en   = done;
    end
  end

  assign in_ch.ready          = (state == S_IDLE);
  assign out_ch.valid         = out_vld;
  assign out_ch.palette_index = out_index;
  assign out_ch.status        = out_status;

  // palette RAM
  always_ff @(posedge clk) begin
    if (wr_en) store[count[ADDR_W-1:0]] <= color;
    if (rd_en) rdata <= store[scan[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (wr_en) count <= count + CNT_W'(1);
      if (out_load) out_vld <= 1'b1;
      else if (out_ch.ready) out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      color <= {in_ch.red, in_ch.green, in_ch.blue};
      scan  <= '0;
    end else if (rd_en) begin
      scan  <= scan + CNT_W'(1);
    end
    rd_idx <= scan[ADDR_W-1:0];
    if (done) begin
      res_index  <= idx_val;
      res_status <= st_val;
    end
    if (out_load) begin
      out_index  <= res_index;
      out_status <= res_status;
    end
  end

endmodule

// File: design/pfi_checker.sv
// ----------------------------------------------------------------------------
// pfi_checker
// Port-level checks for palette_find_or_insert, bound into that module.
// ----------------------------------------------------------------------------
module pfi_checker import pfi_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] palette_index,
  input logic [1:0]       status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(palette_index) && $stable(status))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while searching");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> palette_index == '0)
    else $error("full status with nonzero index");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_FOUND) || (status == ST_ADDED) || (status == ST_FULL))
    else $error("undefined status code");

endmodule

bind palette_find_or_insert pfi_checker u_pfi_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .palette_index (out_ch.palette_index),
  .status        (out_ch.status)
);

// File: test/palette_find_or_insert_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_find_or_insert_tb
// Sends RGB color requests to the palette block and keeps its own copy of the
// palette to predict each index and status. The palette is filled to capacity,
// then hit with stored colors and with colors that no longer fit. Request and
// result sides idle at random in all but the first of the phases.
// ----------------------------------------------------------------------------
module palette_find_or_insert_tb;
  import pfi_pkg::*;

  localparam int     CLK_HALF       = 5;
  localparam int     RESET_CYCLES   = 5;
  localparam int     RAND_PER_PHASE = 350;
  localparam int     NUM_PHASES     = 4;
  localparam int     TAIL_CYCLES    = 300;
  localparam longint CYCLE_LIMIT    = 3_000_000;

  localparam logic [COLOR_W-1:0] DIRECTED [16] = '{
    24'h000000, 24'h000000, 24'hFFFFFF, 24'hFF0000,
    24'h00FF00, 24'h0000FF, 24'h800000, 24'h008000,
    24'h000080, 24'h010101, 24'h7F7F7F, 24'hFFFFFF,
    24'hFF0000, 24'h000001, 24'h000080, 24'h000000
  };

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    status_t          status;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #CLK_HALF clk = ~clk;

  pfi_in_if  in_ch();
  pfi_out_if out_ch();

  palette_find_or_insert u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  color_t             color_queue [$];
  lookup_t            expected_lookups [$];
  color_t             offered [$];
  bit                 known [logic [COLOR_W-1:0]];
  logic [COLOR_W-1:0] palette_copy [PALETTE_DEPTH];
  int                 entry_count_copy = 0;
  idle_mode_t         idle_mode = IDLE_NONE;
  int                 num_issued = 0;
  int                 num_checked = 0;
  int                 num_errors = 0;
  longint             cycle_count = 0;

  function automatic lookup_t lookup_or_append(color_t c);
    lookup_t r;
    for (int i = 0; i < entry_count_copy; i++) begin
      if (palette_copy[i] == c) begin
        r.index  = i[IDX_W-1:0];
        r.status = ST_FOUND;
        return r;
      end
    end
    if (entry_count_copy < PALETTE_DEPTH) begin
      palette_copy[entry_count_copy] = c;
      r.index  = entry_count_copy[IDX_W-1:0];
      r.status = ST_ADDED;
      entry_count_copy++;
    end else begin
      r.index  = '0;
      r.status = ST_FULL;
    end
    return r;
  endfunction

  function automatic bit hold_off(bit sender);
    case (idle_mode)
      IDLE_SENDER:   return sender && ($urandom_range(99) < 70);
      IDLE_RECEIVER: return !sender && ($urandom_range(99) < 70);
      IDLE_BOTH:     return $urandom_range(99) < 12;
      default:       return 1'b0;
    endcase
  endfunction

  // channels lean toward 0x00 and 0xFF
  function automatic logic [7:0] rand_channel();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic issue(color_t c);
    color_queue.push_back(c);
    num_issued++;
    if (!known.exists(c)) begin
      known[c] = 1'b1;
      offered.push_back(c);
    end
  endtask

  task automatic wait_drained();
    while (num_checked < num_issued) @(posedge clk);
  endtask

  // request driver; predicts at acceptance
  always @(posedge clk) begin
    color_t next_color;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_lookups.push_back(lookup_or_append({in_ch.red, in_ch.green, in_ch.blue}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (color_queue.size() > 0 && !hold_off(1'b1)) begin
          next_color  = color_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.red   <= next_color.red;
          in_ch.green <= next_color.green;
          in_ch.blue  <= next_color.blue;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result: index %0d status %0d", $time,
                   out_ch.palette_index, out_ch.status);
          num_errors++;
        end else begin
          want = expected_lookups.pop_front();
          if (want.index !== out_ch.palette_index) begin
            $display("%0t: palette_index mismatch: expected %0d actual %0d", $time,
                     want.index, out_ch.palette_index);
            num_errors++;
          end
          if (want.status !== out_ch.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, out_ch.status);
            num_errors++;
          end
          num_checked++;
        end
      end
      out_ch.ready <= !hold_off(1'b0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    color_t c;
    int     new_pct;
    in_ch.valid  = 1'b0;
    in_ch.red    = '0;
    in_ch.green  = '0;
    in_ch.blue   = '0;
    out_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[k]) issue(color_t'(DIRECTED[k]));
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      idle_mode <= idle_mode_t'(phase);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // new colors fill the palette, then probe the full case
        new_pct = (offered.size() < PALETTE_DEPTH) ? 40 : 25;
        if ($urandom_range(99) < new_pct) begin
          do begin
            c = {rand_channel(), rand_channel(), rand_channel()};
          end while (known.exists(c));
        end else begin
          c = offered[$urandom_range(offered.size() - 1)];
        end
        issue(c);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (num_errors == 0 && expected_lookups.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
